/* hdl/lrsr_pkg.sv */
package lrsr_pkg;

  localparam int NUM_STATES_DEF     = 64;
  localparam int NUM_SYMBOLS_DEF    = 32;
  localparam int STACK_DEPTH_DEF    = 64;
  localparam int MAX_RHS_DEF        = 8;
  localparam int MAX_REDUCTIONS_DEF = 63;

  localparam int MODE_W  = 2;
  localparam int STATE_W = 6;
  localparam int SYM_W   = 5;
  localparam int KIND_W  = 3;
  localparam int LEN_W   = 4;
  localparam int EV_W    = 3;

  localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TOKEN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  localparam logic [KIND_W-1:0] K_EMPTY  = 3'd0;
  localparam logic [KIND_W-1:0] K_SHIFT  = 3'd1;
  localparam logic [KIND_W-1:0] K_REDUCE = 3'd2;
  localparam logic [KIND_W-1:0] K_GOTO   = 3'd3;
  localparam logic [KIND_W-1:0] K_ACCEPT = 3'd4;

  localparam logic [EV_W-1:0] EV_SHIFT   = 3'd0;
  localparam logic [EV_W-1:0] EV_REDUCE  = 3'd1;
  localparam logic [EV_W-1:0] EV_ACCEPT  = 3'd2;
  localparam logic [EV_W-1:0] EV_ERROR   = 3'd3;
  localparam logic [EV_W-1:0] EV_WRITTEN = 3'd4;
  localparam logic [EV_W-1:0] EV_RESTART = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [STATE_W-1:0] target;
    logic [LEN_W-1:0]   rhs_len;
    logic [SYM_W-1:0]   lhs;
  } tbl_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACT,
    ST_EXP,
    ST_GOTO,
    ST_WRITTEN,
    ST_RESTART,
    ST_ERROR
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_SHIFT,
    OP_ACCEPT,
    OP_RED_START,
    OP_GOTO_READ,
    OP_REDUCE,
    OP_ERROR,
    OP_WRITTEN,
    OP_RESTART
  } op_e;

  typedef struct packed {
    logic              clear_done;
    logic              slot_free;
    logic [MODE_W-1:0] mode;
    logic              tok_bad;
    logic              is_shift;
    logic              shift_ok;
    logic              is_accept;
    logic              is_reduce;
    logic              red_ok;
    logic              exp_ok;
    logic              goto_ok;
  } status_t;

endpackage

/* hdl/lrsr_ctrl.sv */
module lrsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lrsr_pkg::status_t sts_i,
  output lrsr_pkg::op_e     op_o
);
  import lrsr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.mode)
            MODE_WRITE:   state_d = ST_WRITTEN;
            MODE_TOKEN:   state_d = sts_i.tok_bad ? ST_ERROR : ST_ACT;
            MODE_RESTART: state_d = ST_RESTART;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACT: begin
        if (sts_i.is_shift) begin
          if (!sts_i.shift_ok) begin
            state_d = ST_ERROR;
          end else if (sts_i.slot_free) begin
            state_d = ST_IDLE;
          end
        end else if (sts_i.is_accept) begin
          if (sts_i.slot_free) begin
            state_d = ST_IDLE;
          end
        end else if (sts_i.is_reduce && sts_i.red_ok) begin
          state_d = ST_EXP;
        end else begin
          state_d = ST_ERROR;
        end
      end
      ST_EXP: begin
        state_d = sts_i.exp_ok ? ST_GOTO : ST_ERROR;
      end
      ST_GOTO: begin
        if (!sts_i.goto_ok) begin
          state_d = ST_ERROR;
        end else if (sts_i.slot_free) begin
          state_d = ST_ACT;
        end
      end
      ST_WRITTEN, ST_RESTART, ST_ERROR: begin
        if (sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_o       = OP_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: op_o = OP_CLEAR;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_o = OP_LATCH;
        end
      end
      ST_ACT: begin
        if (sts_i.is_shift) begin
          if (sts_i.shift_ok && sts_i.slot_free) begin
            op_o = OP_SHIFT;
          end
        end else if (sts_i.is_accept) begin
          if (sts_i.slot_free) begin
            op_o = OP_ACCEPT;
          end
        end else if (sts_i.is_reduce && sts_i.red_ok) begin
          op_o = OP_RED_START;
        end
      end
      ST_EXP: begin
        if (sts_i.exp_ok) begin
          op_o = OP_GOTO_READ;
        end
      end
      ST_GOTO: begin
        if (sts_i.goto_ok && sts_i.slot_free) begin
          op_o = OP_REDUCE;
        end
      end
      ST_WRITTEN: if (sts_i.slot_free) op_o = OP_WRITTEN;
      ST_RESTART: if (sts_i.slot_free) op_o = OP_RESTART;
      ST_ERROR:   if (sts_i.slot_free) op_o = OP_ERROR;
      default:    op_o = OP_NONE;
    endcase
  end

endmodule

/* hdl/lrsr_datapath.sv */
module lrsr_datapath #(
  parameter int NUM_STATES     = lrsr_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS    = lrsr_pkg::NUM_SYMBOLS_DEF,
  parameter int STACK_DEPTH    = lrsr_pkg::STACK_DEPTH_DEF,
  parameter int MAX_RHS        = lrsr_pkg::MAX_RHS_DEF,
  parameter int MAX_REDUCTIONS = lrsr_pkg::MAX_REDUCTIONS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lrsr_pkg::op_e                op_i,
  output lrsr_pkg::status_t            sts_o,
  input  logic [lrsr_pkg::MODE_W-1:0]  mode_i,
  input  logic [lrsr_pkg::STATE_W-1:0] table_state_i,
  input  logic [lrsr_pkg::SYM_W-1:0]   symbol_id_i,
  input  logic [lrsr_pkg::KIND_W-1:0]  entry_kind_i,
  input  logic [lrsr_pkg::STATE_W-1:0] entry_target_i,
  input  logic [lrsr_pkg::LEN_W-1:0]   entry_rhs_len_i,
  input  logic [lrsr_pkg::SYM_W-1:0]   entry_lhs_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lrsr_pkg::EV_W-1:0]    event_res_o,
  output logic [lrsr_pkg::STATE_W-1:0] top_state_o,
  output logic [lrsr_pkg::SYM_W-1:0]   reduced_lhs_o,
  output logic [lrsr_pkg::LEN_W-1:0]   reduced_len_o,
  output logic                         last_o
);
  import lrsr_pkg::*;

  localparam int SYM_AW    = $clog2(NUM_SYMBOLS);
  localparam int ST_AW     = $clog2(NUM_STATES);
  localparam int TBL_AW    = ST_AW + SYM_AW;
  localparam int TBL_DEPTH = NUM_STATES * (2 ** SYM_AW);
  localparam int SK_AW     = $clog2(STACK_DEPTH);
  localparam int SK_CW     = $clog2(STACK_DEPTH + 1);
  localparam int RC_W      = $clog2(MAX_REDUCTIONS + 1);

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [STATE_W-1:0] st,
                                                 input logic [SYM_W-1:0] sy);
    return {ST_AW'(st), SYM_AW'(sy)};
  endfunction

  tbl_word_t          tbl_mem [TBL_DEPTH];
  tbl_word_t          tbl_rdata_q;
  logic               tbl_we, tbl_re;
  logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
  tbl_word_t          tbl_wdata;

  logic [STATE_W-1:0] stk_mem [STACK_DEPTH];
  logic [STATE_W-1:0] stk_rdata_q;
  logic               stk_we, stk_re;
  logic [SK_AW-1:0]   stk_waddr, stk_raddr;
  logic [STATE_W-1:0] stk_wdata;

  logic [TBL_AW-1:0]  clr_cnt_q, clr_cnt_d;
  logic [STATE_W-1:0] top_q, top_d;
  logic [SK_CW-1:0]   count_q, count_d;
  logic               done_q, done_d;
  logic [RC_W-1:0]    red_q, red_d;
  logic [SYM_W-1:0]   sym_q, sym_d;
  logic [SYM_W-1:0]   rlhs_q, rlhs_d;
  logic [LEN_W-1:0]   rlen_q, rlen_d;
  logic [SK_CW-1:0]   remain_q, remain_d;
  logic               exp_zero_q, exp_zero_d;

  logic               out_valid_q, out_valid_d;
  logic [EV_W-1:0]    ev_q, ev_d;
  logic [STATE_W-1:0] otop_q, otop_d;
  logic [SYM_W-1:0]   olhs_q, olhs_d;
  logic [LEN_W-1:0]   olen_q, olen_d;
  logic               olast_q, olast_d;

  logic [SK_CW-1:0]   remain;
  logic [STATE_W-1:0] exposed;

  assign remain  = count_q - SK_CW'(tbl_rdata_q.rhs_len);
  assign exposed = exp_zero_q ? '0 : stk_rdata_q;

  always_comb begin
    sts_o.clear_done = (clr_cnt_q == TBL_AW'(TBL_DEPTH - 1));
    sts_o.slot_free  = !out_valid_q || !out_stall_i;
    sts_o.mode       = mode_i;
    sts_o.tok_bad    = done_q || (32'(symbol_id_i) >= NUM_SYMBOLS);
    sts_o.is_shift   = (tbl_rdata_q.kind == K_SHIFT);
    sts_o.shift_ok   = (32'(tbl_rdata_q.target) < NUM_STATES) &&
                       (32'(count_q) < STACK_DEPTH);
    sts_o.is_accept  = (tbl_rdata_q.kind == K_ACCEPT);
    sts_o.is_reduce  = (tbl_rdata_q.kind == K_REDUCE);
    sts_o.red_ok     = (32'(red_q) < MAX_REDUCTIONS) &&
                       (32'(tbl_rdata_q.rhs_len) <= MAX_RHS) &&
                       (32'(tbl_rdata_q.rhs_len) < 32'(count_q));
    sts_o.exp_ok     = (32'(rlhs_q) < NUM_SYMBOLS);
    sts_o.goto_ok    = (tbl_rdata_q.kind == K_GOTO) &&
                       (32'(tbl_rdata_q.target) < NUM_STATES) &&
                       (32'(remain_q) < STACK_DEPTH);
  end

  always_comb begin
    tbl_we      = 1'b0;
    tbl_waddr   = clr_cnt_q;
    tbl_wdata   = '0;
    tbl_re      = 1'b0;
    tbl_raddr   = tbl_addr(top_q, symbol_id_i);
    stk_we      = 1'b0;
    stk_waddr   = SK_AW'(count_q);
    stk_wdata   = tbl_rdata_q.target;
    stk_re      = 1'b0;
    stk_raddr   = SK_AW'(remain - SK_CW'(1));
    clr_cnt_d   = clr_cnt_q;
    top_d       = top_q;
    count_d     = count_q;
    done_d      = done_q;
    red_d       = red_q;
    sym_d       = sym_q;
    rlhs_d      = rlhs_q;
    rlen_d      = rlen_q;
    remain_d    = remain_q;
    exp_zero_d  = exp_zero_q;
    out_valid_d = out_valid_q && out_stall_i;
    ev_d        = ev_q;
    otop_d      = otop_q;
    olhs_d      = olhs_q;
    olen_d      = olen_q;
    olast_d     = olast_q;
    case (op_i)
      OP_CLEAR: begin
        tbl_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + TBL_AW'(1);
      end
      OP_LATCH: begin
        sym_d  = symbol_id_i;
        red_d  = '0;
        tbl_re = 1'b1;
        if (mode_i == MODE_WRITE && 32'(table_state_i) < NUM_STATES &&
            32'(symbol_id_i) < NUM_SYMBOLS) begin
          tbl_we    = 1'b1;
          tbl_waddr = tbl_addr(table_state_i, symbol_id_i);
          tbl_wdata = '{kind: entry_kind_i, target: entry_target_i,
                        rhs_len: entry_rhs_len_i, lhs: entry_lhs_i};
        end
      end
      OP_SHIFT: begin
        stk_we      = 1'b1;
        count_d     = count_q + SK_CW'(1);
        top_d       = tbl_rdata_q.target;
        out_valid_d = 1'b1;
        ev_d        = EV_SHIFT;
        otop_d      = tbl_rdata_q.target;
        olhs_d      = '0;
        olen_d      = '0;
        olast_d     = 1'b1;
      end
      OP_ACCEPT: begin
        done_d      = 1'b1;
        out_valid_d = 1'b1;
        ev_d        = EV_ACCEPT;
        otop_d      = top_q;
        olhs_d      = '0;
        olen_d      = '0;
        olast_d     = 1'b1;
      end
      OP_RED_START: begin
        stk_re     = 1'b1;
        remain_d   = remain;
        rlhs_d     = tbl_rdata_q.lhs;
        rlen_d     = tbl_rdata_q.rhs_len;
        exp_zero_d = (remain == SK_CW'(1));
      end
      OP_GOTO_READ: begin
        tbl_re    = 1'b1;
        tbl_raddr = tbl_addr(exposed, rlhs_q);
      end
      OP_REDUCE: begin
        stk_we      = 1'b1;
        stk_waddr   = SK_AW'(remain_q);
        count_d     = remain_q + SK_CW'(1);
        top_d       = tbl_rdata_q.target;
        red_d       = red_q + RC_W'(1);
        tbl_re      = 1'b1;
        tbl_raddr   = tbl_addr(tbl_rdata_q.target, sym_q);
        out_valid_d = 1'b1;
        ev_d        = EV_REDUCE;
        otop_d      = tbl_rdata_q.target;
        olhs_d      = rlhs_q;
        olen_d      = rlen_q;
        olast_d     = 1'b0;
      end
      OP_ERROR: begin
        done_d      = 1'b1;
        out_valid_d = 1'b1;
        ev_d        = EV_ERROR;
        otop_d      = top_q;
        olhs_d      = '0;
        olen_d      = '0;
        olast_d     = 1'b1;
      end
      OP_WRITTEN: begin
        out_valid_d = 1'b1;
        ev_d        = EV_WRITTEN;
        otop_d      = top_q;
        olhs_d      = '0;
        olen_d      = '0;
        olast_d     = 1'b1;
      end
      OP_RESTART: begin
        count_d     = SK_CW'(1);
        top_d       = '0;
        done_d      = 1'b0;
        out_valid_d = 1'b1;
        ev_d        = EV_RESTART;
        otop_d      = '0;
        olhs_d      = '0;
        olen_d      = '0;
        olast_d     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rdata_q <= tbl_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      top_q       <= '0;
      count_q     <= SK_CW'(1);
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_cnt_q   <= clr_cnt_d;
      top_q       <= top_d;
      count_q     <= count_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q      <= red_d;
    sym_q      <= sym_d;
    rlhs_q     <= rlhs_d;
    rlen_q     <= rlen_d;
    remain_q   <= remain_d;
    exp_zero_q <= exp_zero_d;
    ev_q       <= ev_d;
    otop_q     <= otop_d;
    olhs_q     <= olhs_d;
    olen_q     <= olen_d;
    olast_q    <= olast_d;
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = ev_q;
  assign top_state_o   = otop_q;
  assign reduced_lhs_o = olhs_q;
  assign reduced_len_o = olen_q;
  assign last_o        = olast_q;

endmodule

/* hdl/lr_shift_reduce_engine.sv */
// Table-driven LR parsing engine. Every input item carries a mode: a table write stores one
// action word at (table_state, symbol_id), a token runs the parser on symbol_id, and a
// restart empties the state stack down to state 0. Each write, token or restart answers with
// result items on the output channel (an item of the unused mode gives none); the one that ends
// an item has last set. A token gives up to MAX_REDUCTIONS reduce results followed by one shift,
// accept or error result. A table write or restart is latched, then gives a single result.
// A token ending in shift or accept reads the action table once, and each reduction adds
// one action-table read, one state-stack read for the exposed state and one goto read, all
// through the single read port of the action table and of the state stack. The next item is
// taken once the previous one has produced its final result into the output register.
// After reset the action table is swept to empty, one entry a cycle, over all
// NUM_STATES * 2**ceil(log2(NUM_SYMBOLS)) entries (2048 by default); no item is taken until
// the sweep ends. When the receiver stalls, the result waits in the output register and
// the engine pauses at its next result until the register is free.
module lr_shift_reduce_engine #(
  parameter int NUM_STATES     = lrsr_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS    = lrsr_pkg::NUM_SYMBOLS_DEF,
  parameter int STACK_DEPTH    = lrsr_pkg::STACK_DEPTH_DEF,
  parameter int MAX_RHS        = lrsr_pkg::MAX_RHS_DEF,
  parameter int MAX_REDUCTIONS = lrsr_pkg::MAX_REDUCTIONS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lrsr_pkg::MODE_W-1:0]  mode_i,
  input  logic [lrsr_pkg::STATE_W-1:0] table_state_i,
  input  logic [lrsr_pkg::SYM_W-1:0]   symbol_id_i,
  input  logic [lrsr_pkg::KIND_W-1:0]  entry_kind_i,
  input  logic [lrsr_pkg::STATE_W-1:0] entry_target_i,
  input  logic [lrsr_pkg::LEN_W-1:0]   entry_rhs_len_i,
  input  logic [lrsr_pkg::SYM_W-1:0]   entry_lhs_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lrsr_pkg::EV_W-1:0]    event_res_o,
  output logic [lrsr_pkg::STATE_W-1:0] top_state_o,
  output logic [lrsr_pkg::SYM_W-1:0]   reduced_lhs_o,
  output logic [lrsr_pkg::LEN_W-1:0]   reduced_len_o,
  output logic                         last_o
);
  import lrsr_pkg::*;

  op_e     op;
  status_t sts;

  lrsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .op_o       (op)
  );

  lrsr_datapath #(
    .NUM_STATES     (NUM_STATES),
    .NUM_SYMBOLS    (NUM_SYMBOLS),
    .STACK_DEPTH    (STACK_DEPTH),
    .MAX_RHS        (MAX_RHS),
    .MAX_REDUCTIONS (MAX_REDUCTIONS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .sts_o           (sts),
    .mode_i          (mode_i),
    .table_state_i   (table_state_i),
    .symbol_id_i     (symbol_id_i),
    .entry_kind_i    (entry_kind_i),
    .entry_target_i  (entry_target_i),
    .entry_rhs_len_i (entry_rhs_len_i),
    .entry_lhs_i     (entry_lhs_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_res_o     (event_res_o),
    .top_state_o     (top_state_o),
    .reduced_lhs_o   (reduced_lhs_o),
    .reduced_len_o   (reduced_len_o),
    .last_o          (last_o)
  );

endmodule

/* tb/tb_lr_shift_reduce_engine.sv */
module tb_lr_shift_reduce_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import lrsr_pkg::*;

  localparam int TABLE_SIZE = NUM_STATES_DEF * NUM_SYMBOLS_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [KIND_W-1:0] K_SPARE = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [STATE_W-1:0] row;
    logic [SYM_W-1:0]   sym;
    logic [KIND_W-1:0]  kind;
    logic [STATE_W-1:0] target;
    logic [LEN_W-1:0]   rhs_len;
    logic [SYM_W-1:0]   lhs;
  } parse_item_t;

  localparam int ITEM_W = $bits(parse_item_t);

  typedef struct packed {
    logic [EV_W-1:0]    ev;
    logic [STATE_W-1:0] top;
    logic [SYM_W-1:0]   lhs;
    logic [LEN_W-1:0]   len;
    logic               last;
  } parse_event_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [MODE_W-1:0]   mode_i = '0;
  logic [STATE_W-1:0]  table_state_i = '0;
  logic [SYM_W-1:0]    symbol_id_i = '0;
  logic [KIND_W-1:0]   entry_kind_i = '0;
  logic [STATE_W-1:0]  entry_target_i = '0;
  logic [LEN_W-1:0]    entry_rhs_len_i = '0;
  logic [SYM_W-1:0]    entry_lhs_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [EV_W-1:0]     event_res_o;
  logic [STATE_W-1:0]  top_state_o;
  logic [SYM_W-1:0]    reduced_lhs_o;
  logic [LEN_W-1:0]    reduced_len_o;
  logic                last_o;

  tbl_word_t           shadow_table [TABLE_SIZE];
  logic [STATE_W-1:0]  shadow_stack [STACK_DEPTH_DEF];
  int                  stack_cnt = 1;
  bit                  parse_over = 1'b0;
  parse_event_t        pending_events [$];
  parse_event_t        want_event;

  int                  send_gap_pct = 0;
  int                  stall_pct = 0;
  bit                  rx_hold = 1'b0;
  int                  fail_cnt = 0;

  logic [SYM_W-1:0]    tok_end, tok_id, tok_plus, tok_open, tok_close, nt_expr, nt_term;
  logic [STATE_W-1:0]  gram_st [9];

  lr_shift_reduce_engine u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("tb_lr_shift_reduce_engine NOT OK");
    $finish;
  end

  function automatic logic [STATE_W-1:0] stack_top();
    return shadow_stack[stack_cnt-1];
  endfunction

  function automatic void push_event(input logic [EV_W-1:0] ev, input logic [STATE_W-1:0] top,
                                     input logic [SYM_W-1:0] lhs, input logic [LEN_W-1:0] len,
                                     input logic last);
    parse_event_t e;
    e = '{ev, top, lhs, len, last};
    pending_events.insert(pending_events.size(), e);
  endfunction

  function automatic void predict_parse_events(input parse_item_t it);
    tbl_word_t w;
    tbl_word_t g;
    int        reductions;
    int        remain;
    bit        running;
    case (it.mode)
      MODE_WRITE: begin
        shadow_table[it.row * NUM_SYMBOLS_DEF + it.sym] = '{it.kind, it.target, it.rhs_len, it.lhs};
        push_event(EV_WRITTEN, stack_top(), '0, '0, 1'b1);
      end
      MODE_TOKEN: begin
        reductions = 0;
        running = !parse_over;
        while (running) begin
          w = shadow_table[stack_top() * NUM_SYMBOLS_DEF + it.sym];
          running = 1'b0;
          if (w.kind == K_SHIFT) begin
            if (stack_cnt < STACK_DEPTH_DEF) begin
              shadow_stack[stack_cnt] = w.target;
              stack_cnt++;
              push_event(EV_SHIFT, w.target, '0, '0, 1'b1);
              return;
            end
          end else if (w.kind == K_ACCEPT) begin
            parse_over = 1'b1;
            push_event(EV_ACCEPT, stack_top(), '0, '0, 1'b1);
            return;
          end else if (w.kind == K_REDUCE && reductions < MAX_REDUCTIONS_DEF &&
                       w.rhs_len <= MAX_RHS_DEF && w.rhs_len < stack_cnt) begin
            remain = stack_cnt - w.rhs_len;
            g = shadow_table[shadow_stack[remain-1] * NUM_SYMBOLS_DEF + w.lhs];
            if (g.kind == K_GOTO && remain < STACK_DEPTH_DEF) begin
              shadow_stack[remain] = g.target;
              stack_cnt = remain + 1;
              reductions++;
              push_event(EV_REDUCE, g.target, w.lhs, w.rhs_len, 1'b0);
              running = 1'b1;
            end
          end
        end
        parse_over = 1'b1;
        push_event(EV_ERROR, stack_top(), '0, '0, 1'b1);
      end
      MODE_RESTART: begin
        shadow_stack[0] = '0;
        stack_cnt = 1;
        parse_over = 1'b0;
        push_event(EV_RESTART, '0, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  always @(negedge clk_i) begin
    out_stall_i <= rx_hold || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result: event_res %0d top_state %0d", event_res_o, top_state_o);
        fail_cnt++;
      end else begin
        want_event = pending_events.pop_front();
        if (event_res_o !== want_event.ev) begin
          $error("event_res expected %0d actual %0d", want_event.ev, event_res_o);
          fail_cnt++;
        end
        if (top_state_o !== want_event.top) begin
          $error("top_state expected %0d actual %0d", want_event.top, top_state_o);
          fail_cnt++;
        end
        if (reduced_lhs_o !== want_event.lhs) begin
          $error("reduced_lhs expected %0d actual %0d", want_event.lhs, reduced_lhs_o);
          fail_cnt++;
        end
        if (reduced_len_o !== want_event.len) begin
          $error("reduced_len expected %0d actual %0d", want_event.len, reduced_len_o);
          fail_cnt++;
        end
        if (last_o !== want_event.last) begin
          $error("last expected %0d actual %0d", want_event.last, last_o);
          fail_cnt++;
        end
      end
    end
  end

  task automatic send_item(input parse_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    mode_i          = it.mode;
    table_state_i   = it.row;
    symbol_id_i     = it.sym;
    entry_kind_i    = it.kind;
    entry_target_i  = it.target;
    entry_rhs_len_i = it.rhs_len;
    entry_lhs_i     = it.lhs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_parse_events(it);
    @(negedge clk_i);
  endtask

  task automatic send_write(input logic [STATE_W-1:0] row, input logic [SYM_W-1:0] sym,
                            input logic [KIND_W-1:0] kind, input logic [STATE_W-1:0] target,
                            input logic [LEN_W-1:0] rhs_len, input logic [SYM_W-1:0] lhs);
    parse_item_t it;
    it = '{MODE_WRITE, row, sym, kind, target, rhs_len, lhs};
    send_item(it);
  endtask

  task automatic send_token(input logic [SYM_W-1:0] sym);
    parse_item_t it;
    it = parse_item_t'(ITEM_W'($urandom));
    it.mode = MODE_TOKEN;
    it.sym = sym;
    send_item(it);
  endtask

  task automatic send_restart();
    parse_item_t it;
    it = parse_item_t'(ITEM_W'($urandom));
    it.mode = MODE_RESTART;
    send_item(it);
  endtask

  task automatic send_unused();
    parse_item_t it;
    it = parse_item_t'(ITEM_W'($urandom));
    it.mode = MODE_UNUSED;
    send_item(it);
  endtask

  task automatic wait_results_drained();
    in_valid_i = 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
  endtask

  task automatic load_grammar();
    bit               used_sym [NUM_SYMBOLS_DEF];
    bit               used_st [NUM_STATES_DEF];
    logic [SYM_W-1:0] picks [7];
    logic [SYM_W-1:0] follow [3];
    for (int i = 0; i < 7; i++) begin
      do picks[i] = SYM_W'($urandom_range(NUM_SYMBOLS_DEF - 1)); while (used_sym[picks[i]]);
      used_sym[picks[i]] = 1'b1;
    end
    {tok_end, tok_id, tok_plus, tok_open, tok_close, nt_expr, nt_term} =
      {picks[0], picks[1], picks[2], picks[3], picks[4], picks[5], picks[6]};
    gram_st[0] = '0;
    used_st[0] = 1'b1;
    for (int i = 1; i < 9; i++) begin
      do gram_st[i] = STATE_W'($urandom_range(NUM_STATES_DEF - 1)); while (used_st[gram_st[i]]);
      used_st[gram_st[i]] = 1'b1;
    end
    send_write(gram_st[0], tok_id, K_SHIFT, gram_st[3], 0, 0);
    send_write(gram_st[0], tok_open, K_SHIFT, gram_st[4], 0, 0);
    send_write(gram_st[0], nt_expr, K_GOTO, gram_st[1], 0, 0);
    send_write(gram_st[0], nt_term, K_GOTO, gram_st[2], 0, 0);
    send_write(gram_st[1], tok_end, K_ACCEPT, 0, 0, 0);
    send_write(gram_st[1], tok_plus, K_SHIFT, gram_st[5], 0, 0);
    send_write(gram_st[4], tok_id, K_SHIFT, gram_st[3], 0, 0);
    send_write(gram_st[4], tok_open, K_SHIFT, gram_st[4], 0, 0);
    send_write(gram_st[4], nt_expr, K_GOTO, gram_st[6], 0, 0);
    send_write(gram_st[4], nt_term, K_GOTO, gram_st[2], 0, 0);
    send_write(gram_st[5], tok_id, K_SHIFT, gram_st[3], 0, 0);
    send_write(gram_st[5], tok_open, K_SHIFT, gram_st[4], 0, 0);
    send_write(gram_st[5], nt_term, K_GOTO, gram_st[7], 0, 0);
    send_write(gram_st[6], tok_close, K_SHIFT, gram_st[8], 0, 0);
    send_write(gram_st[6], tok_plus, K_SHIFT, gram_st[5], 0, 0);
    follow = '{tok_end, tok_plus, tok_close};
    foreach (follow[i]) begin
      send_write(gram_st[2], follow[i], K_REDUCE, 0, 1, nt_expr);
      send_write(gram_st[3], follow[i], K_REDUCE, 0, 1, nt_term);
      send_write(gram_st[7], follow[i], K_REDUCE, 0, 3, nt_expr);
      send_write(gram_st[8], follow[i], K_REDUCE, 0, 3, nt_term);
    end
  endtask

  task automatic test_table_corner_cases();
    send_token(0);
    send_token(31);
    send_unused();
    send_restart();
    send_write(63, 31, K_SPARE, 63, 15, 31);
    send_write(0, 31, K_SHIFT, 63, 0, 0);
    send_token(31);
    send_token(31);
    send_restart();
    send_write(0, 5, K_GOTO, 9, 0, 0);
    send_token(5);
    send_restart();
    send_write(0, 6, K_ACCEPT, 0, 0, 0);
    send_token(6);
    send_token(6);
    send_restart();
    send_write(0, 7, K_REDUCE, 0, 1, 3);
    send_token(7);
    send_restart();
    send_write(0, 10, K_REDUCE, 0, 0, 11);
    send_token(10);
    send_restart();
    send_write(0, 9, K_REDUCE, 0, 0, 4);
    send_write(0, 4, K_GOTO, 0, 0, 0);
    send_token(9);
    send_restart();
    send_write(63, 30, K_SHIFT, 63, 0, 0);
    send_write(63, 29, K_REDUCE, 0, 9, 4);
    send_write(63, 4, K_GOTO, 63, 0, 0);
    send_token(31);
    repeat (9) send_token(30);
    send_token(29);
    send_restart();
    send_write(0, 31, K_EMPTY, 0, 0, 0);
    send_token(31);
    send_restart();
  endtask

  task automatic test_traffic_profile(input int gap, input int stall, input int n_tokens);
    logic [SYM_W-1:0] toks [$];
    int               sent;
    int               depth;
    int               n_terms;
    wait_results_drained();
    send_gap_pct = gap;
    stall_pct = stall;
    sent = 0;
    while (sent < n_tokens) begin
      toks.delete();
      depth = 0;
      n_terms = $urandom_range(1, 3);
      for (int t = 0; t < n_terms; t++) begin
        if (t > 0) toks.insert(toks.size(), tok_plus);
        while (depth < 4 && $urandom_range(99) < 30) begin
          toks.insert(toks.size(), tok_open);
          depth++;
        end
        toks.insert(toks.size(), tok_id);
        while (depth > 0 && $urandom_range(99) < 40) begin
          toks.insert(toks.size(), tok_close);
          depth--;
        end
      end
      while (depth > 0) begin
        toks.insert(toks.size(), tok_close);
        depth--;
      end
      toks.insert(toks.size(), tok_end);
      case ($urandom_range(9))
        0: toks[$urandom_range(toks.size() - 1)] = SYM_W'($urandom);
        1: toks.delete(toks.size() - 1);
        2: toks.insert($urandom_range(toks.size()), SYM_W'($urandom));
        default: ;
      endcase
      if ($urandom_range(19) == 0) begin
        send_write(STATE_W'($urandom), SYM_W'($urandom), KIND_W'($urandom), STATE_W'($urandom),
                   LEN_W'($urandom), SYM_W'($urandom));
      end
      if ($urandom_range(9) == 0) send_unused();
      if ($urandom_range(7) != 0) send_restart();
      foreach (toks[i]) send_token(toks[i]);
      sent += toks.size();
    end
  endtask

  task automatic test_stack_overflow_under_hold();
    wait_results_drained();
    send_gap_pct = 0;
    stall_pct = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (300) @(negedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    send_write(0, 9, K_REDUCE, 0, 0, 4);
    send_write(0, 4, K_GOTO, 0, 0, 0);
    send_write(0, 8, K_SHIFT, 0, 0, 0);
    send_restart();
    send_token(8);
    send_token(9);
    send_restart();
    send_token(9);
    send_restart();
  endtask

  initial begin
    foreach (shadow_table[i]) shadow_table[i] = '0;
    shadow_stack[0] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_table_corner_cases();
    load_grammar();
    test_traffic_profile(0, 0, 6);
    test_traffic_profile(86, 0, 6);
    test_traffic_profile(0, 86, 6);
    test_traffic_profile(38, 38, 6);
    test_stack_overflow_under_hold();
    wait_results_drained();
    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_lr_shift_reduce_engine OK");
    end else begin
      $display("tb_lr_shift_reduce_engine NOT OK");
    end
    $finish;
  end

endmodule

/* lr_shift_reduce_engine.f */
hdl/lrsr_pkg.sv
hdl/lrsr_ctrl.sv
hdl/lrsr_datapath.sv
hdl/lr_shift_reduce_engine.sv
tb/tb_lr_shift_reduce_engine.sv
